/* rtl/itsq_pkg.sv */
// Shared types, constants and helpers of the interval table.
package itsq_pkg;

	localparam int CAPACITY    = 16;
	localparam int COORD_WIDTH = 32;
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int ECNT_W      = 5;

	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_FIND   = 2'd2;

	localparam logic [2:0] STAT_ADDED     = 3'd0;
	localparam logic [2:0] STAT_FULL      = 3'd1;
	localparam logic [2:0] STAT_REMOVED   = 3'd2;
	localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
	localparam logic [2:0] STAT_MATCH     = 3'd4;
	localparam logic [2:0] STAT_NO_MATCH  = 3'd5;

	typedef struct packed {
		logic [1:0]                    op;
		logic signed [COORD_WIDTH-1:0] interval_start;
		logic signed [COORD_WIDTH-1:0] interval_end;
		logic signed [COORD_WIDTH-1:0] query_point;
	} req_t;

	typedef struct packed {
		logic [2:0]                    status;
		logic signed [COORD_WIDTH-1:0] match_start;
		logic signed [COORD_WIDTH-1:0] match_end;
		logic                          last;
		logic [ECNT_W-1:0]             entry_count;
	} rsp_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] iv_start;
		logic signed [COORD_WIDTH-1:0] iv_end;
	} entry_t;

	typedef struct packed {
		logic             add_en;
		logic             rm_en;
		logic             rot_en;
		logic [CNT_W-1:0] count;
		entry_t           key;
	} cell_ctrl_t;

	function automatic logic [ECNT_W-1:0] to_ecnt(input logic [CNT_W-1:0] c);
		logic [ECNT_W+CNT_W-1:0] wide;
		wide = {{ECNT_W{1'b0}}, c};
		return wide[ECNT_W-1:0];
	endfunction

endpackage

/* rtl/itsq_cell.sv */
// One table cell: holds an interval, loads it on add, shifts toward the head on remove and rotate.
module itsq_cell
	import itsq_pkg::*;
(
	input  logic             clk,
	input  logic [CNT_W-1:0] idx,
	input  cell_ctrl_t       ctrl,
	input  entry_t           nxt,
	input  entry_t           head,
	input  logic             found_in,
	output logic             found_out,
	output entry_t           data
);

	entry_t     entry_q;
	logic       valid;
	logic       hit;
	logic       kill;
	logic       tail;

	assign valid     = idx < ctrl.count;
	assign hit       = ctrl.rm_en & valid & (entry_q == ctrl.key);
	assign kill      = found_in | hit;
	assign found_out = kill;
	assign tail      = (idx + CNT_W'(1)) == ctrl.count;
	assign data      = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.add_en && idx == ctrl.count) begin
			entry_q <= ctrl.key;
		end else if (ctrl.rm_en && kill && valid) begin
			entry_q <= nxt;
		end else if (ctrl.rot_en && valid) begin
			entry_q <= tail ? head : nxt;
		end
	end

endmodule

/* rtl/interval_table_stabbing_query_top.sv */
// Interval table top: cell chain, scan sequencer and result register.
// Add and remove: result registered in the cycle after the item, one item per cycle while the output is not stalled.
// Find: the chain rotates once per stored entry through the head cell; no new item is taken
// until the last result is registered, and output stalls hold the scan. One result per match
// in table order, or a single no-match result when nothing matches.
// Reset clears the entry count and control state; stored intervals stay undefined.
module interval_table_stabbing_query_top
	import itsq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_FLUSH = 2'd2;

	logic [1:0]                    state_q;
	logic [CNT_W-1:0]              count_q;
	logic [CNT_W-1:0]              scan_q;
	logic signed [COORD_WIDTH-1:0] point_q;
	logic                          pend_valid_q;
	entry_t                        pend_q;
	logic                          out_valid_q;
	rsp_t                          out_q;

	cell_ctrl_t ctrl;
	entry_t     cell_data [CAPACITY];
	logic       found [CAPACITY+1];
	entry_t     head;
	logic       head_hit;
	logic       out_free;
	logic       in_fire;
	logic       need_push;
	logic       step;
	logic       rm_found;
	logic       is_full;
	logic [CNT_W-1:0] count_nxt;
	logic       out_load;
	rsp_t       out_nxt;

	assign head      = cell_data[0];
	assign head_hit  = (point_q >= head.iv_start) && (point_q <= head.iv_end);
	assign out_free  = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE) && out_free;
	assign in_fire   = req_valid && req_ready;
	assign need_push = head_hit && pend_valid_q;
	assign step      = (state_q == S_SCAN) && (!need_push || out_free);
	assign is_full   = count_q == CNT_W'(CAPACITY);
	assign rm_found  = found[CAPACITY];

	assign ctrl.add_en = in_fire && req.op == OP_ADD && !is_full;
	assign ctrl.rm_en  = in_fire && req.op == OP_REMOVE;
	assign ctrl.rot_en = step;
	assign ctrl.count  = count_q;
	assign ctrl.key    = '{iv_start: req.interval_start, iv_end: req.interval_end};

	assign found[0] = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t nxt;
		if (i < CAPACITY - 1) begin : g_mid
			assign nxt = cell_data[i+1];
		end else begin : g_end
			assign nxt = '0;
		end
		itsq_cell u_cell (
			.clk      (clk),
			.idx      (CNT_W'(i)),
			.ctrl     (ctrl),
			.nxt      (nxt),
			.head     (head),
			.found_in (found[i]),
			.found_out(found[i+1]),
			.data     (cell_data[i])
		);
	end

	always_comb begin
		count_nxt = count_q;
		if (ctrl.add_en) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (ctrl.rm_en && rm_found) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	always_comb begin
		out_load = 1'b0;
		out_nxt  = '0;
		out_nxt.entry_count = to_ecnt(count_nxt);
		out_nxt.last        = 1'b1;
		if (in_fire && req.op == OP_ADD) begin
			out_load       = 1'b1;
			out_nxt.status = is_full ? STAT_FULL : STAT_ADDED;
		end else if (in_fire && req.op == OP_REMOVE) begin
			out_load       = 1'b1;
			out_nxt.status = rm_found ? STAT_REMOVED : STAT_NOT_FOUND;
		end else if (step && need_push) begin
			out_load            = 1'b1;
			out_nxt.status      = STAT_MATCH;
			out_nxt.match_start = pend_q.iv_start;
			out_nxt.match_end   = pend_q.iv_end;
			out_nxt.last        = 1'b0;
		end else if (state_q == S_FLUSH && out_free) begin
			out_load = 1'b1;
			if (pend_valid_q) begin
				out_nxt.status      = STAT_MATCH;
				out_nxt.match_start = pend_q.iv_start;
				out_nxt.match_end   = pend_q.iv_end;
			end else begin
				out_nxt.status = STAT_NO_MATCH;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			scan_q       <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire && req.op == OP_FIND) begin
						scan_q       <= '0;
						pend_valid_q <= 1'b0;
						state_q      <= (count_q == '0) ? S_FLUSH : S_SCAN;
					end
				end
				S_SCAN: begin
					if (step) begin
						if (head_hit) begin
							pend_valid_q <= 1'b1;
						end
						scan_q <= scan_q + CNT_W'(1);
						if (scan_q + CNT_W'(1) == count_q) begin
							state_q <= S_FLUSH;
						end
					end
				end
				S_FLUSH: begin
					if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && req.op == OP_FIND) begin
			point_q <= req.query_point;
		end
		if (step && head_hit) begin
			pend_q <= head;
		end
		if (out_load) begin
			out_q <= out_nxt;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

/* verif/tb_interval_table_stabbing_query_top.sv */
// Testbench for the interval table: add, remove and find items checked against a predicted table.
module tb_interval_table_stabbing_query_top
	import itsq_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PERIOD    = 10;
	localparam int LIMIT     = 300000;
	localparam int END_WAIT  = 2 * (CAPACITY + 4);
	localparam int PHASES    = 10;
	localparam int PHASE_LEN = 25;
	localparam int HOLD_LEN  = 200;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
	localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam coord_t ONE       = coord_t'(32'sh0001_0000);

	typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} mix_e;

	class stab_checker;
		coord_t tab_lo[CAPACITY];
		coord_t tab_hi[CAPACITY];
		int     tab_cnt = 0;
		rsp_t   pending_rsp[$];
		int     mismatches = 0;

		function void note_result(rsp_t x);
			pending_rsp = {pending_rsp, x};
		endfunction

		function void take_request(req_t r);
			coord_t s;
			coord_t e;
			coord_t p;
			rsp_t   x;
			int     i;
			int     hits;
			s = r.interval_start;
			e = r.interval_end;
			p = r.query_point;
			x = '0;
			x.last = 1'b1;
			case (r.op)
				OP_ADD: begin
					if (tab_cnt < CAPACITY) begin
						tab_lo[tab_cnt] = s;
						tab_hi[tab_cnt] = e;
						tab_cnt++;
						x.status = STAT_ADDED;
					end else begin
						x.status = STAT_FULL;
					end
					x.entry_count = tab_cnt[ECNT_W-1:0];
					note_result(x);
				end
				OP_REMOVE: begin
					i = 0;
					while (i < tab_cnt && !(tab_lo[i] == s && tab_hi[i] == e))
						i++;
					if (i < tab_cnt) begin
						while (i + 1 < tab_cnt) begin
							tab_lo[i] = tab_lo[i+1];
							tab_hi[i] = tab_hi[i+1];
							i++;
						end
						tab_cnt--;
						x.status = STAT_REMOVED;
					end else begin
						x.status = STAT_NOT_FOUND;
					end
					x.entry_count = tab_cnt[ECNT_W-1:0];
					note_result(x);
				end
				OP_FIND: begin
					hits = 0;
					x.entry_count = tab_cnt[ECNT_W-1:0];
					for (i = 0; i < tab_cnt; i++) begin
						if (p >= tab_lo[i] && p <= tab_hi[i]) begin
							x.status = STAT_MATCH;
							x.match_start = tab_lo[i];
							x.match_end = tab_hi[i];
							x.last = 1'b0;
							note_result(x);
							hits++;
						end
					end
					if (hits == 0) begin
						x.status = STAT_NO_MATCH;
						note_result(x);
					end else begin
						x = pending_rsp.pop_back();
						x.last = 1'b1;
						note_result(x);
					end
				end
				default: begin
				end
			endcase
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			bit   bad;
			bad = 1'b0;
			if (pending_rsp.size() == 0) begin
				$display("%0t unexpected item: actual status %0d start %h end %h last %b count %0d",
					$time, got.status, got.match_start, got.match_end, got.last,
					got.entry_count);
				mismatches++;
				return;
			end
			want = pending_rsp.pop_front();
			if (got.status !== want.status) begin
				$display("%0t status: expected %0d actual %0d", $time, want.status, got.status);
				bad = 1'b1;
			end
			if (got.match_start !== want.match_start) begin
				$display("%0t match_start: expected %h actual %h", $time,
					want.match_start, got.match_start);
				bad = 1'b1;
			end
			if (got.match_end !== want.match_end) begin
				$display("%0t match_end: expected %h actual %h", $time,
					want.match_end, got.match_end);
				bad = 1'b1;
			end
			if (got.last !== want.last) begin
				$display("%0t last: expected %b actual %b", $time, want.last, got.last);
				bad = 1'b1;
			end
			if (got.entry_count !== want.entry_count) begin
				$display("%0t entry_count: expected %0d actual %0d", $time,
					want.entry_count, got.entry_count);
				bad = 1'b1;
			end
			if (bad)
				mismatches++;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	stab_checker chk;
	bit          calm;
	bit          rx_hold_req;
	int          rx_hold_left;
	int          cycle_cnt;

	interval_table_stabbing_query_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #(PERIOD/2) clk = ~clk;

	function automatic coord_t gen_coord();
		int v;
		case ($urandom_range(0, 9))
			0: return COORD_MIN;
			1: return COORD_MAX;
			2, 3: return coord_t'($urandom);
			default: begin
				v = $urandom_range(0, 40);
				v = v - 20;
				return coord_t'(v * 65536 + ($urandom_range(0, 1) ? 32'h8000 : 0));
			end
		endcase
	endfunction

	function automatic req_t mk_req(logic [1:0] op, coord_t s, coord_t e, coord_t p);
		req_t r;
		r.op = op;
		r.interval_start = s;
		r.interval_end = e;
		r.query_point = p;
		return r;
	endfunction

	function automatic req_t rand_item(mix_e mix);
		req_t   r;
		int     roll;
		int     k;
		int     w_add;
		int     w_rm;
		coord_t t;
		longint mid;
		r = mk_req(OP_FIND, gen_coord(), gen_coord(), gen_coord());
		case (mix)
			MIX_FILL: begin
				w_add = 70;
				w_rm = 5;
			end
			MIX_BALANCED: begin
				w_add = 35;
				w_rm = 30;
			end
			default: begin
				w_add = 10;
				w_rm = 60;
			end
		endcase
		roll = $urandom_range(0, 99);
		if (roll < 2) begin
			r.op = OP_UNUSED;
		end else if (roll < 2 + w_add) begin
			r.op = OP_ADD;
			if (mix == MIX_FILL && $urandom_range(0, 99) < 40) begin
				r.interval_start = COORD_MIN + $urandom_range(0, 255);
				r.interval_end = COORD_MAX - $urandom_range(0, 255);
			end else if (r.interval_start > r.interval_end && $urandom_range(0, 99) < 85) begin
				t = r.interval_start;
				r.interval_start = r.interval_end;
				r.interval_end = t;
			end
		end else if (roll < 2 + w_add + w_rm) begin
			r.op = OP_REMOVE;
			if (chk.tab_cnt > 0 && $urandom_range(0, 99) < 80) begin
				k = $urandom_range(0, chk.tab_cnt - 1);
				r.interval_start = chk.tab_lo[k];
				r.interval_end = chk.tab_hi[k];
				if ($urandom_range(0, 99) < 10)
					r.interval_end = r.interval_end ^ coord_t'(1);
			end
		end else if (chk.tab_cnt > 0 && $urandom_range(0, 99) < 60) begin
			k = $urandom_range(0, chk.tab_cnt - 1);
			case ($urandom_range(0, 2))
				0: r.query_point = chk.tab_lo[k];
				1: r.query_point = chk.tab_hi[k];
				default: begin
					mid = (longint'(chk.tab_lo[k]) + longint'(chk.tab_hi[k])) >>> 1;
					r.query_point = coord_t'(mid);
				end
			endcase
		end
		return r;
	endfunction

	task automatic send_item(req_t r);
		if (!calm && $urandom_range(0, 99) < 27) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
		chk.take_request(r);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (chk.pending_rsp.size() != 0) @(posedge clk);
	endtask

	initial begin
		rsp_ready = 1'b0;
		rx_hold_left = 0;
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready)
				chk.check_response(rsp);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				rx_hold_left = HOLD_LEN;
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= calm || ($urandom_range(0, 99) >= 27);
			end
		end
	end

	initial begin : watchdog
		cycle_cnt = 0;
		while (cycle_cnt < LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int   ph;
		int   n;
		mix_e mix;
		chk = new();
		calm = 1'b0;
		rx_hold_req = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(mk_req(OP_FIND, '0, '0, '0));
		send_item(mk_req(OP_REMOVE, '0, '0, '0));
		send_item(mk_req(OP_ADD, COORD_MIN, COORD_MAX, '0));
		send_item(mk_req(OP_ADD, COORD_MIN, COORD_MIN, '0));
		send_item(mk_req(OP_ADD, COORD_MAX, COORD_MAX, '0));
		send_item(mk_req(OP_ADD, '0, ONE, '0));
		send_item(mk_req(OP_ADD, ONE * 5, -(ONE * 5), '0));
		send_item(mk_req(OP_ADD, -ONE, '0, '0));
		send_item(mk_req(OP_FIND, '0, '0, COORD_MIN));
		send_item(mk_req(OP_FIND, '0, '0, COORD_MAX));
		send_item(mk_req(OP_FIND, '0, '0, '0));
		send_item(mk_req(OP_FIND, '0, '0, ONE * 3));
		send_item(mk_req(OP_FIND, '0, '0, -ONE));
		send_item(mk_req(OP_UNUSED, gen_coord(), gen_coord(), gen_coord()));
		send_item(mk_req(OP_REMOVE, ONE * 5, -(ONE * 5), '0));
		send_item(mk_req(OP_REMOVE, ONE * 5, -(ONE * 5), '0));
		send_item(mk_req(OP_REMOVE, '0, ONE * 2, '0));
		send_item(mk_req(OP_REMOVE, COORD_MIN, COORD_MAX, '0));
		send_item(mk_req(OP_ADD, COORD_MIN, COORD_MAX, '0));
		send_item(mk_req(OP_ADD, COORD_MIN, COORD_MAX, '0));
		send_item(mk_req(OP_REMOVE, COORD_MIN, COORD_MAX, '0));
		send_item(mk_req(OP_FIND, '0, '0, '0));
		wait_drained();

		for (ph = 0; ph < PHASES; ph++) begin
			mix = mix_e'(ph % 3);
			calm = (ph == 4);
			if (ph == 3)
				rx_hold_req = 1'b1;
			for (n = 0; n < PHASE_LEN; n++)
				send_item(rand_item(mix));
			calm = 1'b0;
			wait_drained();
		end

		repeat (END_WAIT) @(posedge clk);
		if (chk.mismatches == 0 && chk.pending_rsp.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
